>>> sv/limit_checked_stepper_mover_defines.svh
// Assertion macros for the stepper mover block.
`ifndef LIMIT_CHECKED_STEPPER_MOVER_DEFINES_SVH
`define LIMIT_CHECKED_STEPPER_MOVER_DEFINES_SVH

`ifndef ASSERT_OFF

`define LCSM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define LCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LCSM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define LCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/lcsm_pkg.sv
`default_nettype none

package lcsm_pkg;

	localparam int POS_BITS        = 10;
	localparam int HALF_W          = 17;
	localparam int STEP_W          = 16;
	localparam int ADDR_W          = 4;
	localparam int DATA_W          = 32;
	localparam int CHECK_CHUNK_DEF = 16;

	localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = HALF_W'(500);

	// Register indexes (byte address is 4 * index)
	localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] REG_LIMIT_LOW   = 2'd1;
	localparam logic [1:0] REG_LIMIT_HIGH  = 2'd2;
	localparam logic [1:0] REG_DRIVE_EN    = 2'd3;

	typedef enum logic [1:0] {
		CMD_TICK       = 2'd0,
		CMD_CHECKED    = 2'd1,
		CMD_MOVE_TO    = 2'd2,
		CMD_FREE       = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE      = 2'd0,
		MODE_CHECKED   = 2'd1,
		MODE_TO        = 2'd2,
		MODE_FREE      = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_UPPER      = 2'd1,
		ERR_LOWER      = 2'd2
	} err_t;

	typedef struct packed {
		logic [HALF_W-1:0]   half_period;
		logic [POS_BITS-1:0] limit_low;
		logic [POS_BITS-1:0] limit_high;
	} cfg_t;

	typedef struct packed {
		logic                step;
		logic                dir;
		logic                busy;
		logic                done;
		err_t                fault;
		logic [POS_BITS-1:0] position;
	} status_t;

endpackage

`default_nettype wire

>>> sv/lcsm_core.sv
`default_nettype none

module lcsm_core #(
	parameter int CHECK_CHUNK = lcsm_pkg::CHECK_CHUNK_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  lcsm_pkg::cmd_t                    cmd,
	input  logic signed [lcsm_pkg::STEP_W-1:0] step_count,
	input  logic [lcsm_pkg::POS_BITS-1:0]     move_target,
	input  logic [lcsm_pkg::POS_BITS-1:0]     pot_sample,
	input  lcsm_pkg::cfg_t                    cfg,
	output lcsm_pkg::status_t                 status
);
	import lcsm_pkg::*;

	localparam int CHUNK_W = $clog2(CHECK_CHUNK + 1);
	localparam logic [CHUNK_W-1:0] CC_CHUNK = CHUNK_W'(CHECK_CHUNK);
	localparam logic [STEP_W-1:0]  CC_STEP  = STEP_W'(CHECK_CHUNK);

	logic [HALF_W-1:0]   htc_q, htc_d, htc_inc;
	logic [STEP_W-1:0]   steps_q, steps_d, steps_dec;
	logic [CHUNK_W-1:0]  chunk_q, chunk_d, chunk_dec;
	mode_t               mode_q, mode_d;
	logic                step_q, step_d;
	logic                dir_q, dir_d;
	err_t                fault_q, fault_d;
	logic [POS_BITS-1:0] latched_q, latched_d;
	logic [POS_BITS-1:0] goal_q, goal_d;
	logic                done, finish;

	logic [STEP_W-1:0]   raw, mag;
	logic                start_dir, goal_ahead;
	logic [POS_BITS-1:0] lim_lo, lim_hi;
	err_t                start_hit, run_hit;

	function automatic err_t limit_check(input logic dir, input logic [POS_BITS-1:0] pos,
			input logic [POS_BITS-1:0] lo, input logic [POS_BITS-1:0] hi);
		err_t r;
		r = ERR_NONE;
		if (!dir && pos >= hi) begin
			r = ERR_UPPER;
		end else if (dir && pos <= lo) begin
			r = ERR_LOWER;
		end
		return r;
	endfunction

	function automatic logic [CHUNK_W-1:0] chunk_for(input logic [STEP_W-1:0] n);
		return (n < CC_STEP) ? CHUNK_W'(n) : CC_CHUNK;
	endfunction

	assign raw        = step_count;
	assign mag        = raw[STEP_W-1] ? (~raw + 1'b1) : raw;
	assign start_dir  = (!raw[STEP_W-1] && raw != '0) ? 1'b0 : 1'b1;
	assign lim_lo     = (cfg.limit_low <= cfg.limit_high) ? cfg.limit_low : cfg.limit_high;
	assign lim_hi     = (cfg.limit_low <= cfg.limit_high) ? cfg.limit_high : cfg.limit_low;
	assign start_hit  = limit_check(start_dir, pot_sample, lim_lo, lim_hi);
	assign run_hit    = limit_check(dir_q, pot_sample, lim_lo, lim_hi);
	assign goal_ahead = !dir_q ? (pot_sample < goal_q) : (pot_sample > goal_q);
	assign htc_inc    = htc_q + 1'b1;
	assign chunk_dec  = (chunk_q != '0) ? chunk_q - 1'b1 : '0;
	assign steps_dec  = (steps_q != '0) ? steps_q - 1'b1 : '0;

	always_comb begin
		htc_d     = htc_q;
		steps_d   = steps_q;
		chunk_d   = chunk_q;
		mode_d    = mode_q;
		step_d    = step_q;
		dir_d     = dir_q;
		fault_d   = fault_q;
		latched_d = latched_q;
		goal_d    = goal_q;
		done      = 1'b0;
		finish    = 1'b0;
		if (en) begin
			if (mode_q == MODE_IDLE) begin
				if (cmd != CMD_TICK) begin
					fault_d = ERR_NONE;
					if (cmd == CMD_MOVE_TO) begin
						latched_d = pot_sample;
						goal_d    = move_target;
						if (move_target == pot_sample) begin
							done = 1'b1;
						end else begin
							dir_d   = (move_target > pot_sample) ? 1'b0 : 1'b1;
							chunk_d = CC_CHUNK;
							mode_d  = MODE_TO;
							step_d  = 1'b1;
							htc_d   = '0;
						end
					end else begin
						dir_d = start_dir;
						if (cmd == CMD_CHECKED) begin
							latched_d = pot_sample;
						end
						if (mag == '0) begin
							done = 1'b1;
						end else if (cmd == CMD_CHECKED && start_hit != ERR_NONE) begin
							fault_d = start_hit;
							done    = 1'b1;
						end else begin
							steps_d = mag;
							chunk_d = chunk_for(mag);
							mode_d  = (cmd == CMD_CHECKED) ? MODE_CHECKED : MODE_FREE;
							step_d  = 1'b1;
							htc_d   = '0;
						end
					end
				end
			end else if (htc_inc >= cfg.half_period) begin
				htc_d = '0;
				if (step_q) begin
					step_d = 1'b0;
				end else if (mode_q == MODE_TO) begin
					if (chunk_dec == '0) begin
						// chunk boundary: latch pot, keep going while short of goal
						latched_d = pot_sample;
						if (goal_ahead) begin
							chunk_d = CC_CHUNK;
							step_d  = 1'b1;
						end else begin
							finish = 1'b1;
						end
					end else begin
						chunk_d = chunk_dec;
						step_d  = 1'b1;
					end
				end else begin
					steps_d = steps_dec;
					chunk_d = chunk_dec;
					if (mode_q == MODE_CHECKED && chunk_dec == '0) begin
						latched_d = pot_sample;
					end
					if (steps_dec == '0) begin
						finish = 1'b1;
					end else if (chunk_dec == '0) begin
						if (mode_q == MODE_CHECKED && run_hit != ERR_NONE) begin
							fault_d = run_hit;
							finish  = 1'b1;
						end else begin
							chunk_d = chunk_for(steps_dec);
							step_d  = 1'b1;
						end
					end else begin
						step_d = 1'b1;
					end
				end
			end else begin
				htc_d = htc_inc;
			end
			if (finish) begin
				mode_d  = MODE_IDLE;
				step_d  = 1'b0;
				htc_d   = '0;
				steps_d = '0;
				chunk_d = '0;
				done    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			htc_q     <= '0;
			steps_q   <= '0;
			chunk_q   <= '0;
			mode_q    <= MODE_IDLE;
			step_q    <= 1'b0;
			dir_q     <= 1'b1;
			fault_q   <= ERR_NONE;
			latched_q <= '0;
			goal_q    <= '0;
		end else begin
			htc_q     <= htc_d;
			steps_q   <= steps_d;
			chunk_q   <= chunk_d;
			mode_q    <= mode_d;
			step_q    <= step_d;
			dir_q     <= dir_d;
			fault_q   <= fault_d;
			latched_q <= latched_d;
			goal_q    <= goal_d;
		end
	end

	assign status.step     = step_d;
	assign status.dir      = dir_d;
	assign status.busy     = (mode_d != MODE_IDLE);
	assign status.done     = done;
	assign status.fault    = fault_d;
	assign status.position = latched_d;

endmodule

`default_nettype wire

>>> sv/limit_checked_stepper_mover.sv
// Step/direction pulse generator with potentiometer limit feedback.
// Input channel (in_valid/in_ready): one request per microsecond tick, carrying
// a command (tick, checked move, move to target, unchecked move), a signed step
// count, a target position and the current pot sample. Commands that arrive
// while a move runs act as plain ticks.
// Output channel (out_valid/out_ready): one result per request with the step,
// direction and enable line levels, busy, move done, error code and the last
// latched position.
// The result of a request accepted at one edge sits in the output register
// from that edge on. Throughput is one request per cycle; the single output
// register sets it, since in_ready is high whenever that register is empty or
// is being drained in the same cycle.
// When the receiver stalls, the result holds and in_ready drops until it is
// taken; no request is lost.
// Registers on the APB port: half period (0x0), lower limit (0x4), upper
// limit (0x8), drive enable (0xC). Write them only while the block is idle.
// Reset: all move state clears, direction line high, half period 500,
// limits 0, driver disabled, no result pending.
`default_nettype none
`include "limit_checked_stepper_mover_defines.svh"

module limit_checked_stepper_mover #(
	parameter int CHECK_CHUNK = lcsm_pkg::CHECK_CHUNK_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lcsm_pkg::ADDR_W-1:0]        paddr,
	input  logic [lcsm_pkg::DATA_W-1:0]        pwdata,
	output logic [lcsm_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         command,
	input  logic signed [lcsm_pkg::STEP_W-1:0] step_count,
	input  logic [lcsm_pkg::POS_BITS-1:0]      move_target,
	input  logic [lcsm_pkg::POS_BITS-1:0]      pot_sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               step_level,
	output logic                               direction_level,
	output logic                               enable_level,
	output logic                               busy_res,
	output logic                               move_done,
	output logic [1:0]                         error_code,
	output logic [lcsm_pkg::POS_BITS-1:0]      position
);
	import lcsm_pkg::*;

	logic [HALF_W-1:0]   half_q;
	logic [POS_BITS-1:0] lim_low_q, lim_high_q;
	logic                drive_en_q;
	logic                cfg_wr, accept;
	cfg_t                cfg;
	status_t             nxt, res_q;
	logic                out_valid_q, enable_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q     <= HALF_PERIOD_RESET;
			lim_low_q  <= '0;
			lim_high_q <= '0;
			drive_en_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_HALF_PERIOD: half_q     <= pwdata[HALF_W-1:0];
				REG_LIMIT_LOW:   lim_low_q  <= pwdata[POS_BITS-1:0];
				REG_LIMIT_HIGH:  lim_high_q <= pwdata[POS_BITS-1:0];
				REG_DRIVE_EN:    drive_en_q <= pwdata[0];
				default:         drive_en_q <= drive_en_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HALF_PERIOD: prdata = DATA_W'(half_q);
			REG_LIMIT_LOW:   prdata = DATA_W'(lim_low_q);
			REG_LIMIT_HIGH:  prdata = DATA_W'(lim_high_q);
			REG_DRIVE_EN:    prdata = DATA_W'(drive_en_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.half_period = half_q;
	assign cfg.limit_low   = lim_low_q;
	assign cfg.limit_high  = lim_high_q;

	// take a request whenever the result slot is free or drains this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	lcsm_core #(
		.CHECK_CHUNK(CHECK_CHUNK)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (accept),
		.cmd         (cmd_t'(command)),
		.step_count  (step_count),
		.move_target (move_target),
		.pot_sample  (pot_sample),
		.cfg         (cfg),
		.status      (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q    <= nxt;
			enable_q <= !drive_en_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign step_level      = res_q.step;
	assign direction_level = res_q.dir;
	assign enable_level    = enable_q;
	assign busy_res        = res_q.busy;
	assign move_done       = res_q.done;
	assign error_code      = res_q.fault;
	assign position        = res_q.position;

	`LCSM_ASSERT_IMPL(a_done_idle, clk, arst_n, out_valid && move_done, !busy_res, "done while busy")
	`LCSM_ASSERT_IMPL(a_fault_idle, clk, arst_n, out_valid && error_code != ERR_NONE, !busy_res, "fault while busy")
	`LCSM_ASSERT_IMPL(a_idle_low, clk, arst_n, out_valid && !busy_res, !step_level, "step high while idle")
	`LCSM_ASSERT_NEXT(a_done_shown, clk, arst_n, accept && nxt.done, out_valid && move_done, "done lost")

endmodule

`default_nettype wire

>>> bench/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lcsm_pkg::*;

	localparam int CHUNK = CHECK_CHUNK_DEF;

	typedef struct packed {
		logic                step;
		logic                dir;
		logic                enable;
		logic                busy;
		logic                done;
		logic [1:0]          fault;
		logic [POS_BITS-1:0] pos;
	} mover_out_t;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                psel            = 1'b0;
	logic                penable         = 1'b0;
	logic                pwrite          = 1'b0;
	logic [ADDR_W-1:0]   paddr           = '0;
	logic [DATA_W-1:0]   pwdata          = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid        = 1'b0;
	logic                in_ready;
	logic [1:0]          command         = CMD_TICK;
	logic [STEP_W-1:0]   step_count      = '0;
	logic [POS_BITS-1:0] move_target     = '0;
	logic [POS_BITS-1:0] pot_sample      = '0;
	logic                out_valid;
	logic                out_ready       = 1'b0;
	logic                step_level;
	logic                direction_level;
	logic                enable_level;
	logic                busy_res;
	logic                move_done;
	logic [1:0]          error_code;
	logic [POS_BITS-1:0] position;

	// mover state as predicted from the accepted requests
	logic [HALF_W-1:0]   cfg_half   = HALF_PERIOD_RESET;
	logic [POS_BITS-1:0] cfg_lim_a  = '0;
	logic [POS_BITS-1:0] cfg_lim_b  = '0;
	logic                cfg_drive  = 1'b0;
	logic [HALF_W-1:0]   tick_cnt   = '0;
	logic [STEP_W-1:0]   steps_rem  = '0;
	logic [10:0]         chunk_rem  = '0;
	mode_t               mover_mode = MODE_IDLE;
	logic                step_q     = 1'b0;
	logic                dir_q      = 1'b1;
	err_t                fault_q    = ERR_NONE;
	logic [POS_BITS-1:0] pos_q      = '0;
	logic [POS_BITS-1:0] goal_q     = '0;

	mover_out_t pending_status[$];
	int         mismatches     = 0;
	int         items_sent     = 0;
	int         plant_pos      = 512;
	int         send_gap_pct   = 0;
	int         recv_stall_pct = 0;

	limit_checked_stepper_mover dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.step_count      (step_count),
		.move_target     (move_target),
		.pot_sample      (pot_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.step_level      (step_level),
		.direction_level (direction_level),
		.enable_level    (enable_level),
		.busy_res        (busy_res),
		.move_done       (move_done),
		.error_code      (error_code),
		.position        (position)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic logic [POS_BITS-1:0] clamp_pos(input int v);
		if (v < 0) return '0;
		if (v > 1023) return 10'd1023;
		return 10'(v);
	endfunction

	function automatic logic [10:0] chunk_of(input logic [STEP_W-1:0] n);
		return (n < CHUNK) ? 11'(n) : 11'(CHUNK);
	endfunction

	// flag the limit in the direction of travel
	function automatic logic at_limit();
		logic [POS_BITS-1:0] lo, hi;
		lo = (cfg_lim_a <= cfg_lim_b) ? cfg_lim_a : cfg_lim_b;
		hi = (cfg_lim_a <= cfg_lim_b) ? cfg_lim_b : cfg_lim_a;
		if (!dir_q && pos_q >= hi) begin
			fault_q = ERR_UPPER;
			return 1'b1;
		end
		if (dir_q && pos_q <= lo) begin
			fault_q = ERR_LOWER;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void advance_mover(input cmd_t cmd, input logic [STEP_W-1:0] count,
		input logic [POS_BITS-1:0] target, input logic [POS_BITS-1:0] pot);
		logic        ends;
		logic [16:0] mag;
		mover_out_t  r;
		ends = 1'b0;
		if (mover_mode == MODE_IDLE) begin
			if (cmd != CMD_TICK) begin
				fault_q = ERR_NONE;
				if (cmd == CMD_MOVE_TO) begin
					pos_q  = pot;
					goal_q = target;
					if (target == pot) begin
						ends = 1'b1;
					end else begin
						dir_q      = (target > pot) ? 1'b0 : 1'b1;
						chunk_rem  = 11'(CHUNK);
						mover_mode = MODE_TO;
						step_q     = 1'b1;
						tick_cnt   = '0;
					end
				end else begin
					mag   = count[15] ? 17'h10000 - {1'b0, count} : {1'b0, count};
					dir_q = (!count[15] && count != 0) ? 1'b0 : 1'b1;
					if (cmd == CMD_CHECKED) pos_q = pot;
					if (mag == 0) begin
						ends = 1'b1;
					end else begin
						if (cmd == CMD_CHECKED) ends = at_limit();
						if (!ends) begin
							steps_rem  = mag[15:0];
							chunk_rem  = chunk_of(mag[15:0]);
							mover_mode = (cmd == CMD_CHECKED) ? MODE_CHECKED : MODE_FREE;
							step_q     = 1'b1;
							tick_cnt   = '0;
						end
					end
				end
			end
		end else begin
			tick_cnt = tick_cnt + 17'd1;
			if (tick_cnt >= cfg_half) begin
				tick_cnt = '0;
				if (step_q) begin
					step_q = 1'b0;
				end else begin
					if (chunk_rem != 0) chunk_rem = chunk_rem - 11'd1;
					if (mover_mode == MODE_TO) begin
						if (chunk_rem == 0) begin
							pos_q = pot;
							if (dir_q ? (pot > goal_q) : (pot < goal_q)) chunk_rem = 11'(CHUNK);
							else ends = 1'b1;
						end
					end else begin
						if (steps_rem != 0) steps_rem = steps_rem - 16'd1;
						if (mover_mode == MODE_CHECKED && chunk_rem == 0) pos_q = pot;
						// last chunk ends the move without a limit check
						if (steps_rem == 0) begin
							ends = 1'b1;
						end else if (chunk_rem == 0) begin
							if (mover_mode == MODE_CHECKED) ends = at_limit();
							if (!ends) chunk_rem = chunk_of(steps_rem);
						end
					end
					// next step starts on the tick that ends this one
					step_q = !ends;
				end
			end
		end
		if (ends) begin
			mover_mode = MODE_IDLE;
			step_q     = 1'b0;
			tick_cnt   = '0;
			steps_rem  = '0;
			chunk_rem  = '0;
		end
		r.step   = step_q;
		r.dir    = dir_q;
		r.enable = !cfg_drive;
		r.busy   = (mover_mode != MODE_IDLE);
		r.done   = ends;
		r.fault  = fault_q;
		r.pos    = pos_q;
		pending_status.push_back(r);
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		mover_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				$error("result arrived with no request outstanding");
				mismatches++;
			end else begin
				want = pending_status.pop_front();
				check_field("step_level", want.step, step_level);
				check_field("direction_level", want.dir, direction_level);
				check_field("enable_level", want.enable, enable_level);
				check_field("busy_res", want.busy, busy_res);
				check_field("move_done", want.done, move_done);
				check_field("error_code", want.fault, error_code);
				check_field("position", want.pos, position);
			end
		end
	end

	// pot sample: mostly the plant, some jitter while moving, noise while idle
	function automatic logic [POS_BITS-1:0] pick_pot();
		if (mover_mode != MODE_IDLE && $urandom_range(0, 7) == 0)
			return clamp_pos(plant_pos + int'($urandom_range(0, 4)) - 2);
		if (mover_mode == MODE_IDLE && $urandom_range(0, 3) == 0)
			return 10'($urandom_range(0, 1023));
		return 10'(plant_pos);
	endfunction

	task automatic send_request(input cmd_t cmd, input logic [STEP_W-1:0] count,
		input logic [POS_BITS-1:0] target, input logic [POS_BITS-1:0] pot);
		logic step_before;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		step_count  <= count;
		move_target <= target;
		pot_sample  <= pot;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		step_before = step_q;
		advance_mover(cmd, count, target, pot);
		// each new step pulse nudges the pot one count along the direction
		if (!step_before && step_q) plant_pos = clamp_pos(plant_pos + (dir_q ? -1 : 1));
		items_sent++;
	endtask

	task automatic send_tick();
		send_request(CMD_TICK, 16'($urandom), 10'($urandom), pick_pot());
	endtask

	task automatic run_until_idle();
		while (mover_mode != MODE_IDLE) send_tick();
	endtask

	// drop valid and hold until every result is back
	task automatic pause_input();
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_HALF_PERIOD: cfg_half  = value[HALF_W-1:0];
			REG_LIMIT_LOW:   cfg_lim_a = value[POS_BITS-1:0];
			REG_LIMIT_HIGH:  cfg_lim_b = value[POS_BITS-1:0];
			REG_DRIVE_EN:    cfg_drive = value[0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [HALF_W-1:0] half, input logic [POS_BITS-1:0] lim_a,
		input logic [POS_BITS-1:0] lim_b, input logic drive);
		pause_input();
		write_reg(REG_HALF_PERIOD, 32'(half));
		write_reg(REG_LIMIT_LOW, 32'(lim_a));
		write_reg(REG_LIMIT_HIGH, 32'(lim_b));
		write_reg(REG_DRIVE_EN, 32'(drive));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_reset_state();
		send_request(CMD_TICK, '0, '0, '0);
		send_request(CMD_TICK, 16'hFFFF, 10'h3FF, 10'h3FF);
		// zero half period, swapped extreme limits
		configure('0, 10'd1023, 10'd0, 1'b1);
	endtask

	task automatic test_zero_steps();
		plant_pos = 512;
		send_request(CMD_CHECKED, 16'h0000, 10'd7, 10'd512);
		send_request(CMD_FREE, 16'h0000, 10'd7, 10'd512);
	endtask

	task automatic test_limit_at_start();
		plant_pos = 1023;
		send_request(CMD_CHECKED, 16'd5, 10'd0, 10'd1023);
		send_tick();
		send_tick();
		plant_pos = 0;
		send_request(CMD_CHECKED, -16'sd5, 10'd0, 10'd0);
		send_tick();
	endtask

	task automatic test_target_equal();
		// also clears the error left by the previous move
		send_request(CMD_MOVE_TO, 16'hFFFF, 10'd0, 10'd0);
		send_tick();
	endtask

	task automatic test_busy_ignored();
		plant_pos = 512;
		send_request(CMD_FREE, 16'd3, 10'd0, 10'd512);
		send_request(CMD_CHECKED, 16'($urandom), 10'($urandom), pick_pot());
		send_request(CMD_MOVE_TO, 16'($urandom), 10'($urandom), pick_pot());
		send_request(CMD_FREE, 16'($urandom), 10'($urandom), pick_pot());
		run_until_idle();
	endtask

	task automatic test_last_chunk();
		configure('0, 10'd100, 10'd116, 1'b0);
		plant_pos = 100;
		send_request(CMD_CHECKED, 16'd16, 10'd0, 10'd100);
		run_until_idle();
	endtask

	task automatic test_limit_mid_move();
		configure(17'd2, 10'd100, 10'd120, 1'b1);
		send_request(CMD_CHECKED, 16'h7FFF, 10'd0, 10'(plant_pos));
		run_until_idle();
		send_request(CMD_CHECKED, 16'h8000, 10'd0, 10'(plant_pos));
		run_until_idle();
	endtask

	task automatic test_half_period_change();
		configure(17'h1FFFF, 10'd0, 10'd1023, 1'b1);
		plant_pos = 500;
		send_request(CMD_FREE, 16'd2, 10'd0, 10'd500);
		repeat (4) send_tick();
		// shorten the half period while the step line is still high
		pause_input();
		write_reg(REG_HALF_PERIOD, 32'd1);
		psel    <= 1'b0;
		penable <= 1'b0;
		run_until_idle();
	endtask

	task automatic test_random_moves(input int quota);
		int                  stop_at, moves, mag, lo, hi, pick;
		logic [STEP_W-1:0]   count;
		logic [POS_BITS-1:0] lim_a, lim_b;
		logic [HALF_W-1:0]   half;
		stop_at = items_sent + quota;
		moves   = 0;
		while (items_sent < stop_at) begin
			if (mover_mode != MODE_IDLE) begin
				if ($urandom_range(0, 15) == 0)
					send_request(cmd_t'($urandom_range(1, 3)), 16'($urandom), 10'($urandom),
						pick_pot());
				else
					send_tick();
			end else begin
				if (moves % 8 == 0) begin
					pick  = $urandom_range(0, 19);
					half  = (pick < 12) ? 17'($urandom_range(0, 1)) :
						(pick < 18) ? 17'($urandom_range(2, 3)) : 17'($urandom_range(4, 6));
					lim_a = ($urandom_range(0, 4) == 0) ? 10'($urandom) :
						clamp_pos(plant_pos + int'($urandom_range(0, 160)) - 80);
					lim_b = ($urandom_range(0, 4) == 0) ? 10'($urandom) :
						clamp_pos(plant_pos + int'($urandom_range(0, 160)) - 80);
					configure(half, lim_a, lim_b, 1'($urandom_range(0, 1)));
				end
				moves++;
				pick = $urandom_range(0, 19);
				if (pick == 0) plant_pos = 0;
				else if (pick == 1) plant_pos = 1023;
				else if (pick < 5) plant_pos = $urandom_range(0, 1023);
				lo    = (cfg_lim_a <= cfg_lim_b) ? cfg_lim_a : cfg_lim_b;
				hi    = (cfg_lim_a <= cfg_lim_b) ? cfg_lim_b : cfg_lim_a;
				mag   = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 48);
				count = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
				pick  = $urandom_range(0, 99);
				if (pick < 35) begin
					// long checked runs only where a limit will stop them
					if ($urandom_range(0, 9) == 0) begin
						if (hi - plant_pos <= 48) count = 16'h7FFF;
						else if (plant_pos - lo <= 48)
							count = $urandom_range(0, 1) ? 16'h8000 : 16'h8001;
					end
					send_request(CMD_CHECKED, count, 10'($urandom), 10'(plant_pos));
				end else if (pick < 65) begin
					send_request(CMD_MOVE_TO, 16'($urandom),
						($urandom_range(0, 9) == 0) ? 10'(plant_pos) :
						clamp_pos(plant_pos + int'($urandom_range(0, 240)) - 120),
						10'(plant_pos));
				end else if (pick < 85) begin
					send_request(CMD_FREE, count, 10'($urandom), 10'(plant_pos));
				end else begin
					send_tick();
				end
			end
		end
	endtask

	task automatic test_target_never_reached();
		run_until_idle();
		configure(17'd1, 10'd0, 10'd1023, 1'b1);
		// pot stays put, so the move keeps stepping
		send_request(CMD_MOVE_TO, 16'($urandom), 10'd400, 10'd300);
		repeat (80) send_request(CMD_TICK, 16'($urandom), 10'($urandom), 10'd300);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct   = 17;
		recv_stall_pct = 69;
		test_reset_state();
		test_zero_steps();
		test_limit_at_start();
		test_target_equal();
		test_busy_ignored();
		test_last_chunk();
		test_limit_mid_move();
		test_half_period_change();
		test_random_moves(420);

		send_gap_pct   = 69;
		recv_stall_pct = 17;
		test_random_moves(420);

		send_gap_pct   = 0;
		recv_stall_pct = 0;
		test_random_moves(420);

		test_target_never_reached();

		pause_input();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
